### hw/rtl/repder_pkg.sv
`default_nettype none

package repder_pkg;

    // Field and datapath widths.
    localparam int VAL_W    = 16;  // Q1.14 matrix entries and abundances
    localparam int FRAC_W   = 14;  // fraction bits of the Q1.14 inputs
    localparam int IDX_W    = 5;   // species index as seen on the ports
    localparam int CNT_W    = 6;   // species count register
    localparam int DER_W    = 32;  // Q3.28 derivative
    localparam int SCORE_W  = 40;  // exact score sum, Q.28
    localparam int TOT_W    = 48;  // mean fitness, Q.28
    localparam int PROD_W   = 56;  // abundance times score
    localparam int ACC_W    = 62;  // sum of up to 32 products of PROD_W bits
    localparam int DIFF_W   = 49;  // score minus mean fitness
    localparam int DPROD_W  = 65;  // abundance times difference

    typedef logic signed [VAL_W-1:0] t_val;

    // Operation carried down the arithmetic pipeline.
    localparam logic [1:0] OP_SCORE = 2'd0;
    localparam logic [1:0] OP_MEAN  = 2'd1;
    localparam logic [1:0] OP_DERIV = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [1:0]       op;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_ctl;

endpackage

`default_nettype wire

### hw/rtl/repder_matrix.sv
`default_nettype none

module repder_matrix
    import repder_pkg::*;
#(
    parameter int MAX_SPECIES = 32,
    parameter int MW          = $clog2(MAX_SPECIES * MAX_SPECIES)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr_en,
    input  wire logic [MW-1:0] i_wr_addr,
    input  wire t_val          i_wr_data,
    input  wire logic [MW-1:0] i_rd_addr,
    output t_val               o_rd_data,
    output logic               o_clearing
);

    localparam int DEPTH = MAX_SPECIES * MAX_SPECIES;

    t_val          mem [DEPTH];
    logic          r_clearing;
    logic [MW-1:0] r_clr_addr;
    t_val          r_rd_data;

    logic          wr_en;
    logic [MW-1:0] wr_addr;
    t_val          wr_data;

    // After reset every entry is swept to zero before the block takes items.
    assign wr_en   = r_clearing || i_wr_en;
    assign wr_addr = r_clearing ? r_clr_addr : i_wr_addr;
    assign wr_data = r_clearing ? '0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == MW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

`default_nettype wire

### hw/rtl/repder_core.sv
`default_nettype none

module repder_core
    import repder_pkg::*;
#(
    parameter int MAX_SPECIES = 32,
    parameter int MW          = $clog2(MAX_SPECIES * MAX_SPECIES),
    parameter int AW          = $clog2(MAX_SPECIES)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_run,
    input  wire logic [CNT_W-1:0]   i_dim,
    input  wire logic               i_pop_we,
    input  wire logic [AW-1:0]      i_pop_addr,
    input  wire t_val               i_pop_data,
    output logic [MW-1:0]           o_mat_rd_addr,
    input  wire t_val               i_mat_rd_data,
    output logic                    o_busy,
    output logic                    o_strobe,
    output logic [IDX_W-1:0]        o_index,
    output logic signed [DER_W-1:0] o_derivative,
    output logic                    o_final
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCORE = 3'd1;
    localparam logic [2:0] S_MEAN  = 3'd2;
    localparam logic [2:0] S_DERIV = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;

    // Sequencer.
    logic [2:0]       r_state, n_state;
    logic [2:0]       r_after, n_after;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;
    logic [MW-1:0]    r_base, n_base;
    logic [CNT_W-1:0] r_dim;
    logic [IDX_W-1:0] last_idx;
    t_ctl             issue;

    // Memories and pipeline.
    t_val                     pop_mem   [MAX_SPECIES];
    logic signed [SCORE_W-1:0] score_mem [MAX_SPECIES];
    t_val                      r_pop_q;
    logic signed [SCORE_W-1:0] r_score_q;
    t_ctl                      r_c1, r_c2, r_c3;

    logic signed [SCORE_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [DIFF_W-1:0]  r_diff;
    t_val                      r_yd;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   acc_sum;
    logic signed [TOT_W-1:0]   r_tot;
    logic signed [DPROD_W-1:0] r_prod2;
    logic signed [DPROD_W-1:0] shifted;
    logic                      fits;
    logic signed [DER_W-1:0]   sat;

    logic                      r_strobe;
    logic [IDX_W-1:0]          r_index;
    logic signed [DER_W-1:0]   r_derivative;
    logic                      r_final;

    assign last_idx = IDX_W'(r_dim - 1'b1);

    always_comb begin
        n_state = r_state;
        n_after = r_after;
        n_i     = r_i;
        n_j     = r_j;
        n_base  = r_base;
        issue   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_run) begin
                    n_state = S_SCORE;
                    n_i     = '0;
                    n_j     = '0;
                    n_base  = '0;
                end
            end
            S_SCORE: begin
                issue.valid = 1'b1;
                issue.op    = OP_SCORE;
                issue.first = (r_j == '0);
                issue.last  = (r_j == last_idx);
                issue.idx   = r_i;
                if (r_j == last_idx) begin
                    n_j    = '0;
                    n_base = r_base + MW'(MAX_SPECIES);
                    if (r_i == last_idx) begin
                        n_i     = '0;
                        n_state = S_DRAIN;
                        n_after = S_MEAN;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_MEAN, S_DERIV: begin
                issue.valid = 1'b1;
                issue.op    = (r_state == S_MEAN) ? OP_MEAN : OP_DERIV;
                issue.first = (r_i == '0);
                issue.last  = (r_i == last_idx);
                issue.idx   = r_i;
                if (r_i == last_idx) begin
                    n_i     = '0;
                    n_state = S_DRAIN;
                    n_after = (r_state == S_MEAN) ? S_DERIV : S_IDLE;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_DRAIN: begin
                // Scores and the mean must be written back before the next pass reads them.
                if (!r_c1.valid && !r_c2.valid && !r_c3.valid) begin
                    n_state = r_after;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_base  <= '0;
            r_dim   <= CNT_W'(1);
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_i     <= n_i;
            r_j     <= n_j;
            r_base  <= n_base;
            if (r_state == S_IDLE && i_run) begin
                r_dim <= i_dim;
            end
        end
    end

    assign o_mat_rd_addr = r_base + MW'(r_j);

    // Population and score memories, registered reads.
    always_ff @(posedge i_clk) begin
        if (i_pop_we) begin
            pop_mem[i_pop_addr] <= i_pop_data;
        end
        r_pop_q <= pop_mem[(r_state == S_SCORE) ? AW'(r_j) : AW'(r_i)];
    end

    always_ff @(posedge i_clk) begin
        if (r_c2.valid && r_c2.op == OP_SCORE && r_c2.last) begin
            score_mem[AW'(r_c2.idx)] <= acc_sum[SCORE_W-1:0];
        end
        r_score_q <= score_mem[AW'(r_i)];
    end

    // Pipeline control: issue, read, multiply, accumulate or second multiply.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
        end else begin
            r_c1 <= issue;
            r_c2 <= r_c1;
            r_c3 <= r_c2;
        end
    end

    assign mul_b = (r_c1.op == OP_SCORE) ? SCORE_W'(i_mat_rd_data) : r_score_q;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(r_pop_q) * PROD_W'(mul_b);
        r_diff <= DIFF_W'(r_score_q) - DIFF_W'(r_tot);
        r_yd   <= r_pop_q;
    end

    assign acc_sum = r_c2.first ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (r_c2.valid && r_c2.op != OP_DERIV) begin
            r_acc <= acc_sum;
        end
        r_prod2 <= DPROD_W'(r_yd) * DPROD_W'(r_diff);
    end

    // Arithmetic shift floors, matching the rounding of both shifts by the fraction width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot <= '0;
        end else if (r_c2.valid && r_c2.op == OP_MEAN && r_c2.last) begin
            r_tot <= TOT_W'(acc_sum >>> FRAC_W);
        end
    end

    assign shifted = r_prod2 >>> FRAC_W;
    assign fits    = (shifted[DPROD_W-1:DER_W-1] == '0) || (shifted[DPROD_W-1:DER_W-1] == '1);
    assign sat     = fits ? shifted[DER_W-1:0]
                   : (shifted[DPROD_W-1] ? {1'b1, {(DER_W-1){1'b0}}}
                                         : {1'b0, {(DER_W-1){1'b1}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_c3.valid && r_c3.op == OP_DERIV;
        end
    end

    always_ff @(posedge i_clk) begin
        r_index      <= r_c3.idx;
        r_derivative <= sat;
        r_final      <= r_c3.last;
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_index      = r_index;
    assign o_derivative = r_derivative;
    assign o_final      = r_final;

endmodule

`default_nettype wire

### hw/rtl/replicator_derivative.sv
`default_nettype none

// Replicator-equation derivative engine. Matrix and population items are taken
// while busy is low. A population item with last set starts a run over n species:
// n*n score products, then n products for the mean fitness, then n derivatives,
// all through one multiply-accumulate pipeline fed by registered memory reads. Results
// leave on o_strobe, one per cycle during the final pass, and the receiver cannot stall
// them: each is valid for one cycle only. After reset the interaction matrix is cleared
// one entry a cycle, with busy held high until it is done; species count writes are
// taken throughout.

module replicator_derivative
    import repder_pkg::*;
#(
    parameter int MAX_SPECIES = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CNT_W-1:0]        i_cfg_data,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic                    i_kind,
    input  wire logic [IDX_W-1:0]        i_entry_row,
    input  wire logic [IDX_W-1:0]        i_entry_col,
    input  wire logic [IDX_W-1:0]        i_species_index,
    input  wire logic signed [VAL_W-1:0] i_value,
    input  wire logic                    i_last,
    output logic                         o_strobe,
    output logic [IDX_W-1:0]             o_out_index,
    output logic signed [DER_W-1:0]      o_derivative,
    output logic                         o_final_res
);

    localparam int MW      = $clog2(MAX_SPECIES * MAX_SPECIES);
    localparam int AW      = $clog2(MAX_SPECIES);
    localparam int IW      = (AW > IDX_W) ? AW : IDX_W;
    localparam int DIM_LIM = (MAX_SPECIES < 32) ? MAX_SPECIES : 32;

    logic [CNT_W-1:0] r_species_count;
    logic [CNT_W-1:0] dim;
    logic             accept;
    logic             mat_we;
    logic [MW-1:0]    mat_wr_addr;
    logic [MW-1:0]    mat_rd_addr;
    t_val             mat_rd_data;
    logic             clearing;
    logic             pop_we;
    logic [IW-1:0]    sp_ext;
    logic             run;
    logic             core_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_species_count <= CNT_W'(1);
        end else if (i_cfg_we) begin
            r_species_count <= i_cfg_data;
        end
    end

    // A count of zero runs as one; counts past the store size, or past 32, are clipped.
    always_comb begin
        dim = (r_species_count == '0) ? CNT_W'(1) : r_species_count;
        if (dim > CNT_W'(DIM_LIM)) begin
            dim = CNT_W'(DIM_LIM);
        end
    end

    assign busy   = core_busy || clearing;
    assign accept = start && !busy;

    assign mat_we = accept && !i_kind
                 && (int'(i_entry_row) < MAX_SPECIES) && (int'(i_entry_col) < MAX_SPECIES);
    assign mat_wr_addr = MW'(int'(i_entry_row) * MAX_SPECIES + int'(i_entry_col));

    assign pop_we = accept && i_kind && (int'(i_species_index) < MAX_SPECIES);
    assign sp_ext = IW'(i_species_index);
    assign run    = accept && i_kind && i_last;

    repder_matrix #(
        .MAX_SPECIES (MAX_SPECIES),
        .MW          (MW)
    ) u_matrix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (mat_we),
        .i_wr_addr  (mat_wr_addr),
        .i_wr_data  (i_value),
        .i_rd_addr  (mat_rd_addr),
        .o_rd_data  (mat_rd_data),
        .o_clearing (clearing)
    );

    repder_core #(
        .MAX_SPECIES (MAX_SPECIES),
        .MW          (MW),
        .AW          (AW)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_run         (run),
        .i_dim         (dim),
        .i_pop_we      (pop_we),
        .i_pop_addr    (sp_ext[AW-1:0]),
        .i_pop_data    (i_value),
        .o_mat_rd_addr (mat_rd_addr),
        .i_mat_rd_data (mat_rd_data),
        .o_busy        (core_busy),
        .o_strobe      (o_strobe),
        .o_index       (o_out_index),
        .o_derivative  (o_derivative),
        .o_final       (o_final_res)
    );

endmodule

`default_nettype wire
